// ----- rtl/core/pbc_pkg.sv -----
// Package for the polygon band clipper: widths, register indexes, codes and word types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pbc_pkg;

    // Coordinate width and the widths derived from it.
    localparam int CW  = 32;
    localparam int DW  = CW + 1;          // exact difference of two coordinates
    localparam int PW  = 64;              // product width, wraps modulo 2^64
    localparam int MCW = $clog2(DW);      // multiplier step counter
    localparam int PCW = $clog2(PW);      // divider step counter

    // Configuration port.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_CLIP_AXIS = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_BAND_LOW  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BAND_HIGH = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SHIFT_X   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SHIFT_Y   = 3'd4;

    // Input opcodes.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    // Where a coordinate lies relative to the band.
    typedef enum logic [1:0] {
        ZONE_IN   = 2'd0,
        ZONE_LOW  = 2'd1,
        ZONE_HIGH = 2'd2
    } t_zone;

    // What one result slot produces.
    typedef enum logic [1:0] {
        KIND_VTX = 2'd0,
        KIND_LO  = 2'd1,
        KIND_HI  = 2'd2
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_SLOT = 3'd1,
        ST_MUL  = 3'd2,
        ST_DIV  = 3'd3,
        ST_EMIT = 3'd4
    } t_state;

    typedef struct packed {
        logic                 opcode;
        logic signed [CW-1:0] vert_x;
        logic signed [CW-1:0] vert_y;
    } t_in_word;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic                 run_end;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/core/pbc_mul.sv -----
// Bit-serial signed multiplier for the crossing numerator, one multiplier bit per cycle.
// Depends on pbc_pkg for the difference and product widths.
`default_nettype none

module pbc_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [pbc_pkg::DW-1:0] i_a,
    input  wire logic signed [pbc_pkg::DW-1:0] i_b,
    output logic                             o_done,
    output logic [pbc_pkg::PW-1:0]           o_prod
);
    import pbc_pkg::*;

    logic signed [DW-1:0] r_a;
    logic [DW-1:0]        r_b;
    logic signed [DW:0]   r_acc;
    logic [DW-1:0]        r_lo;
    logic [MCW-1:0]       r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic signed [DW+1:0] pp;
    logic signed [DW+1:0] n_sum;
    logic signed [2*DW:0] full;

    // The top bit of the multiplier carries negative weight, so the last step subtracts.
    always_comb begin
        pp = r_b[0] ? (DW+2)'(r_a) : '0;
        if (r_cnt == MCW'(DW - 1)) begin
            n_sum = (DW+2)'(r_acc) - pp;
        end else begin
            n_sum = (DW+2)'(r_acc) + pp;
        end
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MCW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add datapath: the high half accumulates, low bits drop into r_lo.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_acc <= n_sum[DW+1:1];
            r_lo  <= {n_sum[0], r_lo[DW-1:1]};
            r_b   <= r_b >> 1;
        end
    end

    // The full product is wrapped to the product width.
    assign full   = {r_acc, r_lo};
    assign o_prod = PW'(full);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/pbc_div.sv -----
// Radix-2 restoring divider on magnitudes with a signed, truncating result.
// Depends on pbc_pkg; keeps only the low coordinate-width bits of the quotient.
`default_nettype none

module pbc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pbc_pkg::PW-1:0]        i_num,
    input  wire logic signed [pbc_pkg::DW-1:0] i_den,
    output logic                               o_done,
    output logic [pbc_pkg::CW-1:0]             o_quo
);
    import pbc_pkg::*;

    logic [PW-1:0]  r_num;
    logic [DW-1:0]  r_den;
    logic [DW-1:0]  r_rem;
    logic [CW-1:0]  r_q;
    logic [CW-1:0]  r_quo;
    logic           r_neg;
    logic           r_zero;
    logic [PCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_fix;
    logic           r_done;

    logic [PW-1:0]  num_mag;
    logic [DW-1:0]  den_mag;
    logic [DW:0]    trial;
    logic [DW+1:0]  diff;
    logic           take;
    logic [DW-1:0]  n_rem;

    // Magnitudes of the operands at load time.
    always_comb begin
        num_mag = i_num[PW-1] ? (~i_num + 1'b1) : i_num;
        den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    // One quotient bit per cycle: bring down a dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_num[PW-1]};
        diff  = {1'b0, trial} - {2'b00, r_den};
        take  = !diff[DW+1];
        n_rem = take ? diff[DW-1:0] : trial[DW-1:0];
    end

    // Step control: PW steps, then a fix step that applies the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == PCW'(PW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= num_mag;
            r_den  <= den_mag;
            r_rem  <= '0;
            r_neg  <= i_num[PW-1] ^ i_den[DW-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[PW-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= {r_q[CW-2:0], take};
        end else if (r_fix) begin
            // A zero divisor yields a zero quotient.
            if (r_zero) begin
                r_quo <= '0;
            end else if (r_neg) begin
                r_quo <= ~r_q + 1'b1;
            end else begin
                r_quo <= r_q;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ----- rtl/core/polygon_band_clip.sv -----
// Top level of the polygon band clipper: configuration, vertex sequencer and output register.
// Depends on pbc_pkg, pbc_mul and pbc_div.
//
//   channel   direction  handshake                 word
//   input     in         i_in_valid / o_in_ready   i_in_word  (t_in_word)
//   output    out        o_out_valid / i_out_ready o_out_word (t_out_word)
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A start word or a vertex that yields nothing is taken in the idle state; an inside vertex
// passes through the slot and emit steps. Each boundary crossing runs CW+1 multiplier steps
// and 64 divider steps in the shared serial units, so a vertex crossing both bounds runs two
// crossings. One word is in work at a time; o_in_ready is high only when idle.
// A stalled output holds the sequencer at its emit step, which holds off the next input word;
// a waiting output word alone does not block input while the sequencer is idle.
// Reset clears the configuration registers, the previous vertex, its zone and the sequencer.
`default_nettype none

module polygon_band_clip (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pbc_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [pbc_pkg::CW-1:0]       i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire pbc_pkg::t_in_word            i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output pbc_pkg::t_out_word                o_out_word
);
    import pbc_pkg::*;

    // Configuration registers.
    logic                 r_clip_axis;
    logic signed [CW-1:0] r_band_low;
    logic signed [CW-1:0] r_band_high;
    logic signed [CW-1:0] r_shift_x;
    logic signed [CW-1:0] r_shift_y;

    // Polygon state and the word in work.
    logic signed [CW-1:0] r_prev_x;
    logic signed [CW-1:0] r_prev_y;
    t_zone                r_prev_zone;
    logic signed [CW-1:0] r_cur_x;
    logic signed [CW-1:0] r_cur_y;
    t_zone                r_cur_zone;
    t_kind                r_kind0;
    t_kind                r_kind1;
    logic                 r_two;
    logic                 r_idx;
    logic [CW-1:0]        r_res_x;
    logic [CW-1:0]        r_res_y;
    t_state               r_state;
    t_state               n_state;
    logic                 r_out_valid;
    t_out_word            r_out;

    // Decode of the incoming word.
    logic signed [CW-1:0] in_axis;
    t_zone                in_zone;
    t_zone                prev_pz;
    logic                 in_dup;
    logic [1:0]           plan_cnt;
    t_kind                plan_kind0;
    t_kind                plan_kind1;
    logic                 in_accept;

    // Slot datapath.
    t_kind                cur_kind;
    logic                 slot_last;
    logic signed [CW-1:0] bound;
    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [DW-1:0] div_den;
    logic [PW-1:0]        prod;
    logic                 mul_done;
    logic [CW-1:0]        quo;
    logic                 div_done;

    // Sequencer strobes.
    logic                 take_plan;
    logic                 upd_from_in;
    logic                 mul_start;
    logic                 div_start;
    logic                 load_vtx;
    logic                 load_cross;
    logic                 out_load;
    logic                 finish;
    logic                 next_slot;

    function automatic t_zone zone_of(input logic signed [CW-1:0] c,
                                      input logic signed [CW-1:0] lo,
                                      input logic signed [CW-1:0] hi);
        t_zone z;
        if (c <= lo) begin
            z = ZONE_LOW;
        end else if (c >= hi) begin
            z = ZONE_HIGH;
        end else begin
            z = ZONE_IN;
        end
        return z;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_axis <= 1'b0;
            r_band_low  <= '0;
            r_band_high <= '0;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLIP_AXIS: r_clip_axis <= i_cfg_data[0];
                CFG_BAND_LOW:  r_band_low  <= i_cfg_data;
                CFG_BAND_HIGH: r_band_high <= i_cfg_data;
                CFG_SHIFT_X:   r_shift_x   <= i_cfg_data;
                CFG_SHIFT_Y:   r_shift_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zone of the new vertex and of the previous one.
    always_comb begin
        in_axis = r_clip_axis ? i_in_word.vert_x : i_in_word.vert_y;
        in_zone = zone_of(in_axis, r_band_low, r_band_high);
        in_dup  = (i_in_word.vert_x == r_prev_x) && (i_in_word.vert_y == r_prev_y);
        case (r_prev_zone)
            ZONE_IN:  prev_pz = ZONE_IN;
            ZONE_LOW: prev_pz = ZONE_LOW;
            default:  prev_pz = ZONE_HIGH;
        endcase
    end

    // Plan of up to two results from the zone transition.
    always_comb begin
        plan_cnt   = 2'd0;
        plan_kind0 = KIND_VTX;
        plan_kind1 = KIND_VTX;
        case (in_zone)
            ZONE_LOW: begin
                if (prev_pz == ZONE_IN) begin
                    plan_cnt   = 2'd1;
                    plan_kind0 = KIND_LO;
                end else if (prev_pz == ZONE_HIGH) begin
                    plan_cnt   = 2'd2;
                    plan_kind0 = KIND_HI;
                    plan_kind1 = KIND_LO;
                end
            end
            ZONE_HIGH: begin
                if (prev_pz == ZONE_IN) begin
                    plan_cnt   = 2'd1;
                    plan_kind0 = KIND_HI;
                end else if (prev_pz == ZONE_LOW) begin
                    plan_cnt   = 2'd2;
                    plan_kind0 = KIND_LO;
                    plan_kind1 = KIND_HI;
                end
            end
            default: begin
                if (prev_pz == ZONE_IN) begin
                    plan_cnt = in_dup ? 2'd0 : 2'd1;
                end else begin
                    plan_cnt   = 2'd2;
                    plan_kind0 = (prev_pz == ZONE_LOW) ? KIND_LO : KIND_HI;
                end
            end
        endcase
        if (i_in_word.opcode == OP_START) begin
            plan_cnt = 2'd0;
        end
    end

    // Operands of the crossing for the current slot.
    always_comb begin
        cur_kind  = r_idx ? r_kind1 : r_kind0;
        slot_last = r_idx || !r_two;
        bound     = (cur_kind == KIND_LO) ? r_band_low : r_band_high;
        if (r_clip_axis) begin
            mul_a   = DW'(r_cur_y) - DW'(r_prev_y);
            mul_b   = DW'(bound) - DW'(r_prev_x);
            div_den = DW'(r_cur_x) - DW'(r_prev_x);
        end else begin
            mul_a   = DW'(r_cur_x) - DW'(r_prev_x);
            mul_b   = DW'(bound) - DW'(r_prev_y);
            div_den = DW'(r_cur_y) - DW'(r_prev_y);
        end
    end

    pbc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    pbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign in_accept = i_in_valid && o_in_ready;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        take_plan   = 1'b0;
        upd_from_in = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        load_vtx    = 1'b0;
        load_cross  = 1'b0;
        out_load    = 1'b0;
        finish      = 1'b0;
        next_slot   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_accept) begin
                    if (plan_cnt == 2'd0) begin
                        upd_from_in = 1'b1;
                    end else begin
                        take_plan = 1'b1;
                        n_state   = ST_SLOT;
                    end
                end
            end
            ST_SLOT: begin
                if (cur_kind == KIND_VTX) begin
                    load_vtx = 1'b1;
                    n_state  = ST_EMIT;
                end else begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    load_cross = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    if (slot_last) begin
                        finish  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        next_slot = 1'b1;
                        n_state   = ST_SLOT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Previous vertex and slot index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_zone <= ZONE_IN;
            r_idx       <= 1'b0;
            r_two       <= 1'b0;
        end else begin
            if (upd_from_in) begin
                r_prev_x    <= i_in_word.vert_x;
                r_prev_y    <= i_in_word.vert_y;
                r_prev_zone <= in_zone;
            end else if (finish) begin
                r_prev_x    <= r_cur_x;
                r_prev_y    <= r_cur_y;
                r_prev_zone <= r_cur_zone;
            end
            if (take_plan) begin
                r_idx <= 1'b0;
                r_two <= (plan_cnt == 2'd2);
            end else if (next_slot) begin
                r_idx <= 1'b1;
            end
        end
    end

    // Word in work and the result of the current slot.
    always_ff @(posedge i_clk) begin
        if (take_plan) begin
            r_cur_x    <= i_in_word.vert_x;
            r_cur_y    <= i_in_word.vert_y;
            r_cur_zone <= in_zone;
            r_kind0    <= plan_kind0;
            r_kind1    <= plan_kind1;
        end
        if (load_vtx) begin
            r_res_x <= r_cur_x;
            r_res_y <= r_cur_y;
        end else if (load_cross) begin
            if (r_clip_axis) begin
                r_res_x <= bound;
                r_res_y <= r_prev_y + quo;
            end else begin
                r_res_x <= r_prev_x + quo;
                r_res_y <= bound;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_x   <= r_res_x + r_shift_x;
            r_out.out_y   <= r_res_y + r_shift_y;
            r_out.run_end <= slot_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/pbc_checker.sv -----
// Port-level checks for the polygon band clipper and the bind that attaches them.
// Depends on pbc_pkg and on the port list of polygon_band_clip.
`default_nettype none

module pbc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire pbc_pkg::t_in_word          i_in_word,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire pbc_pkg::t_out_word         o_out_word
);
    import pbc_pkg::*;

    // Reset leaves no output word pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // A start word never produces a result.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.opcode == OP_START) && !o_out_valid
        |=> !o_out_valid)
        else $error("start word produced an output word");

    // A new output word only follows a cycle in which the block was busy.
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output word appeared while the block was idle");

endmodule

bind polygon_band_clip pbc_checker u_pbc_checker (.*);

`default_nettype wire
